/* sv/adsr_pkg.sv */
// shared types, codes and constants of the adsr envelope shaper
package adsr_pkg;

	localparam int LEVEL_BITS     = 16;
	localparam int SAMPLE_BITS    = 16;
	localparam int COUNT_BITS_DEF = 24;
	localparam int REG_IDX_BITS   = 3;
	localparam int DIV_CNT_BITS   = $clog2(LEVEL_BITS);

	localparam int ATTACK_RESET  = 4800;
	localparam int DECAY_RESET   = 4800;
	localparam int RELEASE_RESET = 4800;
	localparam int TOTAL_RESET   = 48000;
	localparam int PEAK_RESET    = 65535;
	localparam int SUSTAIN_RESET = 32767;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_RELEASE = 3'd2,
		REG_TOTAL   = 3'd3,
		REG_PEAK    = 3'd4,
		REG_SUSTAIN = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_ATTACK  = 3'd0,
		PH_DECAY   = 3'd1,
		PH_SUSTAIN = 3'd2,
		PH_RELEASE = 3'd3,
		PH_END     = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_PAST  = 2'd2
	} status_t;

	// how the nominal lengths were fitted into the note
	typedef enum logic [1:0] {
		MODE_FULL        = 2'd0,
		MODE_SHORT_DECAY = 2'd1,
		MODE_NO_DECAY    = 2'd2
	} mode_t;

	typedef enum logic {
		JOB_START = 1'b0,
		JOB_LEVEL = 1'b1
	} job_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          note_start;
	} in_beat_t;

	typedef struct packed {
		logic signed [LEVEL_BITS:0] sample_out;
		logic [LEVEL_BITS-1:0]      envelope_level;
		phase_t                     phase;
		status_t                    status;
	} out_beat_t;

	typedef struct packed {
		logic load;
		logic classify;
		logic decide;
		logic prep;
		logic mul;
		logic div_step;
		logic fix;
		logic scale;
		job_t job;
	} ctl_cmd_t;

	typedef struct packed {
		phase_t phase;
		mode_t  mode;
		logic   t_ge_att;
		logic   a_ge_att;
		logic   div_last;
		logic   out_busy;
	} ctl_stat_t;

endpackage

/* sv/adsr_ctl.sv */
// sequencer of the adsr envelope shaper
module adsr_ctl import adsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output ctl_cmd_t  cmd,
	input  ctl_stat_t stat
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_CLASS  = 9'b000000010,
		S_DECIDE = 9'b000000100,
		S_ROUTE  = 9'b000001000,
		S_PREP   = 9'b000010000,
		S_MUL    = 9'b000100000,
		S_DIV    = 9'b001000000,
		S_FIX    = 9'b010000000,
		S_SCALE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	job_t   job_q, job_d;
	logic   need_start, need_level;

	// release from a shortened envelope needs its start level divided out first
	assign need_start = (stat.phase == PH_RELEASE) &&
		((stat.mode == MODE_SHORT_DECAY) || ((stat.mode == MODE_NO_DECAY) && !stat.a_ge_att));
	assign need_level = ((stat.phase == PH_ATTACK) && !stat.t_ge_att) ||
		(stat.phase == PH_DECAY) || (stat.phase == PH_RELEASE);

	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		cmd     = '0;
		cmd.job = job_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CLASS;
				end
			end
			S_CLASS: begin
				cmd.classify = 1'b1;
				state_d      = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_ROUTE;
			end
			S_ROUTE: begin
				if (need_start) begin
					job_d   = JOB_START;
					state_d = S_PREP;
				end else if (need_level) begin
					job_d   = JOB_LEVEL;
					state_d = S_PREP;
				end else begin
					state_d = S_SCALE;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = S_FIX;
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				if (job_q == JOB_START) begin
					job_d   = JOB_LEVEL;
					state_d = S_PREP;
				end else begin
					state_d = S_SCALE;
				end
			end
			S_SCALE: begin
				// hold until the previous result beat has left
				if (!stat.out_busy) begin
					cmd.scale = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= JOB_LEVEL;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

endmodule

/* sv/adsr_dp.sv */
// datapath of the adsr envelope shaper: registers, compares, multiplier, serial divider
module adsr_dp import adsr_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int CFG_W      = (COUNT_BITS > LEVEL_BITS) ? COUNT_BITS : LEVEL_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [REG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  in_beat_t                in_data,
	input  ctl_cmd_t                cmd,
	output ctl_stat_t               stat,
	output logic                    out_valid,
	input  logic                    out_ready,
	output out_beat_t               out_data
);

	localparam int C = COUNT_BITS;
	localparam int L = LEVEL_BITS;
	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(L - 1);

	// configuration
	logic [C-1:0] att_q, dec_q, rel_q, tot_q;
	logic [L-1:0] peak_q, sus_q;

	// item state
	logic [C:0]                    idx_q, t_q, t_next, ad_q, end_q;
	logic signed [C:0]             tr_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [C-1:0]                  a_q, d_q;
	mode_t                         mode_q;
	logic                          bad_q, a_ge_q, t_ge_q;
	phase_t                        phase_q;
	status_t                       status_q;
	logic [L-1:0]                  level_q, start_q;

	// multiply and divide job
	logic [L-1:0]            ma_q, base_q, quo_q;
	logic [C-1:0]            mb_q, div_q, rem_q;
	logic                    neg_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;

	out_beat_t out_q;
	logic      out_valid_q;

	// classify
	logic signed [C+1:0] tr_x, ad_x, att_x;
	assign tr_x  = {tr_q[C], tr_q};
	assign ad_x  = $signed({1'b0, ad_q});
	assign att_x = $signed({2'b00, att_q});

	// phase decision
	logic [C:0] tr_u;
	logic       t_le_a, t_le_end, t_le_tr, t_le_tot;
	phase_t     ph_d;
	status_t    st_d;
	logic [L-1:0] lvl_d;
	assign tr_u     = {1'b0, tr_q[C-1:0]};
	assign t_le_a   = t_q <= {1'b0, a_q};
	assign t_le_end = t_q <= end_q;
	assign t_le_tr  = t_q <= tr_u;
	assign t_le_tot = t_q <= {1'b0, tot_q};

	always_comb begin
		st_d = STAT_OK;
		if (bad_q) begin
			ph_d = PH_END;
			st_d = STAT_SHORT;
		end else if (t_le_a)   ph_d = PH_ATTACK;
		else if (t_le_end)     ph_d = PH_DECAY;
		else if (t_le_tr)      ph_d = PH_SUSTAIN;
		else if (t_le_tot)     ph_d = PH_RELEASE;
		else begin
			ph_d = PH_END;
			st_d = STAT_PAST;
		end
		case (ph_d)
			PH_ATTACK:  lvl_d = peak_q;
			PH_SUSTAIN: lvl_d = sus_q;
			default:    lvl_d = '0;
		endcase
	end

	// operand selection for the next multiply and divide
	logic         dk_neg;
	logic [L-1:0] dk_span, pa, pbase;
	logic [C-1:0] pb, pdiv;
	logic         pneg;
	assign dk_neg  = sus_q < peak_q;
	assign dk_span = dk_neg ? (peak_q - sus_q) : (sus_q - peak_q);

	always_comb begin
		pa    = peak_q;
		pb    = t_q[C-1:0];
		pdiv  = att_q;
		pneg  = 1'b0;
		pbase = '0;
		if (cmd.job == JOB_START) begin
			if (mode_q == MODE_SHORT_DECAY) begin
				pa    = dk_span;
				pb    = d_q;
				pdiv  = dec_q;
				pneg  = dk_neg;
				pbase = peak_q;
			end else begin
				pb = a_q;
			end
		end else begin
			case (phase_q)
				PH_DECAY: begin
					pa    = dk_span;
					pb    = t_q[C-1:0] - att_q;
					pdiv  = dec_q;
					pneg  = dk_neg;
					pbase = peak_q;
				end
				PH_RELEASE: begin
					pa   = start_q;
					pb   = tot_q - t_q[C-1:0];
					pdiv = rel_q;
				end
				default: ;
			endcase
		end
	end

	// quotient is known to fit the level width, so the high part starts below the divisor
	logic [L+C-1:0] prod;
	logic [C:0]     shifted;
	logic           ge;
	logic [L:0]     fix_sum;
	assign prod    = ma_q * mb_q;
	assign shifted = {rem_q, quo_q[L-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign fix_sum = neg_q ?
		({1'b0, base_q} - {1'b0, quo_q} - {{L{1'b0}}, rem_q != '0}) :
		({1'b0, base_q} + {1'b0, quo_q});

	logic signed [SAMPLE_BITS+L:0] scaled;
	assign scaled = x_q * $signed({1'b0, level_q});

	assign t_next = in_data.note_start ? '0 : idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q       <= C'(ATTACK_RESET);
			dec_q       <= C'(DECAY_RESET);
			rel_q       <= C'(RELEASE_RESET);
			tot_q       <= C'(TOTAL_RESET);
			peak_q      <= L'(PEAK_RESET);
			sus_q       <= L'(SUSTAIN_RESET);
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_ATTACK:  att_q  <= cfg_data[C-1:0];
					REG_DECAY:   dec_q  <= cfg_data[C-1:0];
					REG_RELEASE: rel_q  <= cfg_data[C-1:0];
					REG_TOTAL:   tot_q  <= cfg_data[C-1:0];
					REG_PEAK:    peak_q <= cfg_data[L-1:0];
					REG_SUSTAIN: sus_q  <= cfg_data[L-1:0];
					default: ;
				endcase
			end
			// counter saturates at all ones
			if (cmd.load) idx_q <= (&t_next) ? t_next : t_next + 1'b1;
			if (cmd.scale)                  out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q  <= t_next;
			x_q  <= in_data.sample_in;
			ad_q <= {1'b0, att_q} + {1'b0, dec_q};
			tr_q <= $signed({1'b0, tot_q}) - $signed({1'b0, rel_q});
		end
		if (cmd.classify) begin
			a_ge_q <= tr_x >= att_x;
			bad_q  <= 1'b0;
			d_q    <= tr_q[C-1:0] - att_q;
			if (tr_x > ad_x) begin
				mode_q <= MODE_FULL;
				a_q    <= att_q;
				end_q  <= ad_q;
			end else if (tr_x > att_x) begin
				mode_q <= MODE_SHORT_DECAY;
				a_q    <= att_q;
				end_q  <= tr_u;
			end else begin
				mode_q <= MODE_NO_DECAY;
				a_q    <= tr_q[C-1:0];
				end_q  <= tr_u;
				bad_q  <= tr_q[C] || (tr_q == '0);
			end
		end
		if (cmd.decide) begin
			phase_q  <= ph_d;
			status_q <= st_d;
			level_q  <= lvl_d;
			t_ge_q   <= t_q >= {1'b0, att_q};
			start_q  <= (mode_q == MODE_FULL) ? sus_q : peak_q;
		end
		if (cmd.prep) begin
			ma_q   <= pa;
			mb_q   <= pb;
			div_q  <= pdiv;
			neg_q  <= pneg;
			base_q <= pbase;
		end
		if (cmd.mul) begin
			rem_q <= prod[L+C-1:L];
			quo_q <= prod[L-1:0];
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? C'(shifted - {1'b0, div_q}) : shifted[C-1:0];
			quo_q <= {quo_q[L-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.fix) begin
			if (cmd.job == JOB_START) start_q <= fix_sum[L-1:0];
			else                      level_q <= fix_sum[L-1:0];
		end
		if (cmd.scale) begin
			out_q.sample_out     <= scaled[SAMPLE_BITS-1 +: L+1];
			out_q.envelope_level <= level_q;
			out_q.phase          <= phase_q;
			out_q.status         <= status_q;
		end
	end

	assign stat.phase    = phase_q;
	assign stat.mode     = mode_q;
	assign stat.t_ge_att = t_ge_q;
	assign stat.a_ge_att = a_ge_q;
	assign stat.div_last = cnt_q == DIV_LAST;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/adsr_envelope_shaper_top.sv */
// top level of the adsr envelope shaper
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    in_data (sample_in, note_start)
// out       output     out_valid/out_ready  out_data (sample_out, envelope_level, phase, status)
// cfg       input      cfg_write            cfg_index, cfg_data
//
// an item needs zero, one or two divisions, each by the serial divider at one quotient bit a cycle
// release may need two runs
// reset loads the default lengths and levels and clears the sample counter
// a new beat is taken as soon as the sequencer is idle, even with a result still waiting
// a finished result waits in the last step while the previous out beat is held
module adsr_envelope_shaper_top import adsr_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int CFG_W      = (COUNT_BITS > LEVEL_BITS) ? COUNT_BITS : LEVEL_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [REG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  in_beat_t                in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output out_beat_t               out_data
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	adsr_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	adsr_dp #(
		.COUNT_BITS (COUNT_BITS),
		.CFG_W      (CFG_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input beat taken while an item is in work");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale |-> !(out_valid && !out_ready))
		else $error("result written over a waiting out beat");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.scale))
		else $error("out_valid rose without a scale step");

	// no envelope means silence
	a_silent_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status != STAT_OK)) |->
		((out_data.envelope_level == '0) && (out_data.sample_out == '0) &&
		(out_data.phase == PH_END)))
		else $error("nonzero output with an error status");

endmodule

/* test/adsr_envelope_shaper_top_tb.sv */
// self-checking testbench of the adsr envelope shaper with a built-in envelope predictor
module adsr_envelope_shaper_top_tb import adsr_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFG_W = (COUNT_BITS_DEF > LEVEL_BITS) ? COUNT_BITS_DEF : LEVEL_BITS;
	localparam int unsigned COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;
	localparam longint POS_MAX = (64'sd1 << (COUNT_BITS_DEF + 1)) - 1;
	localparam longint Q_ONE = 64'sd1 << (SAMPLE_BITS - 1);
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 850;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [REG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_beat_t out_data;

	adsr_envelope_shaper_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// predictor copy of the registers and the sample counter
	longint att_len = ATTACK_RESET;
	longint dec_len = DECAY_RESET;
	longint rel_len = RELEASE_RESET;
	longint note_len = TOTAL_RESET;
	longint peak_lvl = PEAK_RESET;
	longint sus_lvl = SUSTAIN_RESET;
	longint note_pos = 0;

	in_beat_t pending_samples[$];
	out_beat_t expected_shaped[$];
	int mismatch_count = 0;
	int unsigned queued_items = 0;

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	int unsigned ready_mode = 0;
	bit long_hold_done = 1'b0;
	int unsigned idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint floor_div(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint attack_at(longint t);
		if (t >= att_len)
			return peak_lvl;
		return (peak_lvl * t) / att_len;
	endfunction

	// decay slope always follows the nominal attack and decay lengths
	function automatic longint decay_at(longint t);
		if (dec_len == 0)
			return sus_lvl;
		return peak_lvl + floor_div((sus_lvl - peak_lvl) * (t - att_len), dec_len);
	endfunction

	function automatic out_beat_t shape_sample(in_beat_t beat);
		longint slack, a, d, start, t, level, x, prod;
		phase_t ph;
		status_t st;
		bit bad;
		out_beat_t res;
		if (beat.note_start)
			note_pos = 0;
		t = note_pos;
		start = 0;
		level = 0;
		bad = 1'b0;
		st = STAT_OK;
		slack = note_len - att_len - dec_len - rel_len;
		if (slack > 0) begin
			a = att_len;
			d = dec_len;
			start = sus_lvl;
		end else if (dec_len + slack > 0) begin
			a = att_len;
			d = dec_len + slack;
			start = decay_at(att_len + d);
		end else begin
			a = att_len + dec_len + slack;
			d = 0;
			if (a <= 0)
				bad = 1'b1;
			else
				start = attack_at(a);
		end
		if (bad) begin
			ph = PH_END;
			st = STAT_SHORT;
		end else if (t <= a) begin
			ph = PH_ATTACK;
			level = attack_at(t);
		end else if (t <= a + d) begin
			ph = PH_DECAY;
			level = decay_at(t);
		end else if (t <= note_len - rel_len) begin
			ph = PH_SUSTAIN;
			level = sus_lvl;
		end else if (t <= note_len) begin
			ph = PH_RELEASE;
			level = (rel_len == 0) ? 0 : (start * (note_len - t)) / rel_len;
		end else begin
			ph = PH_END;
			st = STAT_PAST;
		end
		x = beat.sample_in;
		prod = floor_div(x * level, Q_ONE);
		res.sample_out = prod[LEVEL_BITS:0];
		res.envelope_level = level[LEVEL_BITS-1:0];
		res.phase = ph;
		res.status = st;
		if (note_pos < POS_MAX)
			note_pos = note_pos + 1;
		return res;
	endfunction

	function automatic void check_field(string name, integer want, integer got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_BITS'(-(1 <<< (SAMPLE_BITS - 1)));
			1: return SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic int unsigned rand_level();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return (1 << LEVEL_BITS) - 1;
			default: return $urandom_range(0, (1 << LEVEL_BITS) - 1);
		endcase
	endfunction

	task automatic queue_beat(logic signed [SAMPLE_BITS-1:0] smp, bit start);
		in_beat_t b;
		b.sample_in = smp;
		b.note_start = start;
		pending_samples.insert(pending_samples.size(), b);
		queued_items++;
	endtask

	task automatic queue_note(int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			queue_beat(rand_sample(), i == 0);
	endtask

	task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ATTACK:  att_len = val[COUNT_BITS_DEF-1:0];
			REG_DECAY:   dec_len = val[COUNT_BITS_DEF-1:0];
			REG_RELEASE: rel_len = val[COUNT_BITS_DEF-1:0];
			REG_TOTAL:   note_len = val[COUNT_BITS_DEF-1:0];
			REG_PEAK:    peak_lvl = val[LEVEL_BITS-1:0];
			REG_SUSTAIN: sus_lvl = val[LEVEL_BITS-1:0];
			default: ;
		endcase
	endtask

	// level writes carry junk above the level width, spare indexes must be ignored
	task automatic program_envelope(int unsigned a, int unsigned d, int unsigned r,
			int unsigned t, int unsigned p, int unsigned s);
		write_reg(REG_SPARE_LO, CFG_W'($urandom()));
		write_reg(REG_ATTACK, CFG_W'(a));
		write_reg(REG_DECAY, CFG_W'(d));
		write_reg(REG_RELEASE, CFG_W'(r));
		write_reg(REG_TOTAL, CFG_W'(t));
		write_reg(REG_PEAK, {8'($urandom()), 16'(p)});
		write_reg(REG_SUSTAIN, {8'($urandom()), 16'(s)});
		write_reg(REG_SPARE_HI, CFG_W'($urandom()));
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// look between edges so a beat popped or taken at this edge is already visible
	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || expected_shaped.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic pick_envelope();
		int unsigned a, d, r, t;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				// everything fits, sustain between decay and release
				a = $urandom_range(0, 6);
				d = $urandom_range(0, 6);
				r = $urandom_range(0, 6);
				t = a + d + r + $urandom_range(1, 8);
			end
			3, 4: begin
				// decay cut short
				a = $urandom_range(0, 6);
				d = $urandom_range(2, 10);
				r = $urandom_range(0, 6);
				t = a + r + $urandom_range(1, d);
			end
			5, 6: begin
				// no decay left, attack cut short
				a = $urandom_range(2, 40);
				d = $urandom_range(0, 5);
				r = $urandom_range(0, 6);
				t = r + $urandom_range(1, a);
			end
			7: begin
				// release eats the whole note
				r = $urandom_range(1, 10);
				t = $urandom_range(0, r);
				a = $urandom_range(0, 8);
				d = $urandom_range(0, 8);
			end
			8: begin
				a = ($urandom_range(0, 1) != 0) ? COUNT_MAX : $urandom_range(1, 6);
				d = ($urandom_range(0, 1) != 0) ? COUNT_MAX : $urandom_range(1, 6);
				r = ($urandom_range(0, 1) != 0) ? COUNT_MAX : $urandom_range(1, 6);
				t = COUNT_MAX;
			end
			default: begin
				// huge nominal attack squeezed into a short note
				a = COUNT_MAX;
				d = $urandom_range(0, 5);
				r = $urandom_range(0, 8);
				t = $urandom_range(20, 40);
			end
		endcase
		program_envelope(a, d, r, t, rand_level(), rand_level());
	endtask

	// sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_samples.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pending_samples.pop_front();
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches at random intervals, plus one long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!long_hold_done && pending_samples.size() > 50) begin
				out_ready <= 1'b0;
				hold_left <= LONG_HOLD;
				long_hold_done <= 1'b1;
			end else begin
				case (ready_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ~out_ready;
				endcase
			end
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(8, 64);
			end else begin
				mode_left <= mode_left - 1;
			end
		end
	end

	// check the out beat first so an unexpected one is never masked by a new entry
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_shaped.size() == 0) begin
					$display("%0t ns: result beat expected none got %h", $time, out_data);
					mismatch_count++;
				end else begin
					want = expected_shaped.pop_front();
					check_field("sample_out", want.sample_out, out_data.sample_out);
					check_field("envelope_level", want.envelope_level, out_data.envelope_level);
					check_field("phase", want.phase, out_data.phase);
					check_field("status", want.status, out_data.status);
				end
			end
			if (in_valid && in_ready)
				expected_shaped.insert(expected_shaped.size(), shape_sample(in_data));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned phase_items, len;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset lengths, start of a long attack
		queue_beat(16'sh7fff, 1'b1);
		queue_beat(-16'sh8000, 1'b0);
		queue_beat(-16'sh0001, 1'b0);
		queue_beat(16'sh0001, 1'b0);
		wait_idle();

		// short note through every phase into past end
		program_envelope(2, 2, 3, 8, 65535, 20000);
		for (int i = 0; i < 10; i++)
			queue_beat((i % 2) ? -16'sh8000 : 16'sh7fff, i == 0);
		wait_idle();

		// note too short for the lengths
		program_envelope(1, 1, 5, 5, 0, 65535);
		queue_beat(16'sh7fff, 1'b1);
		queue_beat(-16'sh8000, 1'b0);
		wait_idle();

		// zero attack, decay and release lengths
		program_envelope(0, 0, 0, 3, 65535, 65535);
		queue_beat(-16'sh8000, 1'b1);
		queue_beat(16'sh7fff, 1'b0);
		queue_beat(-16'sh0001, 1'b0);
		queue_beat(16'sh0000, 1'b0);
		queue_beat(16'sh3039, 1'b0);
		wait_idle();

		while (queued_items < RANDOM_ITEMS) begin
			pick_envelope();
			phase_items = $urandom_range(60, 120);
			while (pending_samples.size() < phase_items) begin
				case ($urandom_range(0, 9))
					0: begin
						// note broken off early
						len = (note_len > 4) ? $urandom_range(1, 20) : 1;
						queue_note(len);
					end
					1: begin
						// stray beats with random note start
						for (int i = $urandom_range(1, 5); i > 0; i--)
							queue_beat(rand_sample(), 1'($urandom_range(0, 1)));
					end
					default: begin
						if (note_len <= 64)
							len = 32'(note_len + $urandom_range(1, 4));
						else
							len = $urandom_range(4, 40);
						queue_note(len);
					end
				endcase
			end
			wait_idle();
		end

		while (pending_samples.size() != 0 || in_valid || expected_shaped.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
